// ===== hw/rtl/bdq_pkg.sv =====
// ---------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque unit.
// ---------------------------------------------------------------------------
package bdq_pkg;

    localparam int BDQ_DEPTH = 64;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 7;
    localparam int OP_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

// ===== hw/rtl/bounded_deque_unit.sv =====
// ---------------------------------------------------------------------------
// bounded_deque_unit
// Bounded double-ended queue of signed 32-bit values in a circular RAM.
//
//  channel  | dir | tdata (low bit up)               | tuser      | tlast
//  ---------+-----+----------------------------------+------------+------------
//  s_axis   | in  | operand[31:0]                    | op[2:0]    | -
//  m_axis   | out | data[31:0] status[1:0] occ[6:0]  | has_data   | last result
//
//  Push, pop and empty-list transactions: back to back while the output is not stalled.
//  Listing n entries: one entry per cycle while the output is not stalled, paced by the
//  single RAM read port and its registered read; no input taken meanwhile.
//  Reset clears state, indices, count and output valid; output data and the RAM keep no reset.
//  A stalled output holds its result; the next input is taken in the cycle
//  the waiting result leaves.
// ---------------------------------------------------------------------------
module bounded_deque_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH = BDQ_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand[31:0]
    input  logic [2:0]  s_tuser,   // op[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // data[31:0], status[33:32], occupancy[40:34], zero
    output logic        m_tuser,   // has_data
    output logic        m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               pend_last_reg, pend_last_next;
    logic               m_valid_reg, m_valid_next;

    logic [DATA_W-1:0]  m_data_reg, m_data_next;
    status_t            m_status_reg, m_status_next;
    logic [OCC_W-1:0]   m_occ_reg, m_occ_next;
    logic               m_has_reg, m_has_next;
    logic               m_last_reg, m_last_next;

    logic [DATA_W-1:0]  mem [DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;
    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;

    logic               out_free, s_acc, move, issue, load, full;
    op_t                op;
    status_t            stat;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign full     = (cnt_reg >= CNT_W'(DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        iss_next       = iss_reg;
        rd_pend_next   = rd_pend_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_status_next  = m_status_reg;
        m_occ_next     = m_occ_reg;
        m_has_next     = m_has_reg;
        m_last_next    = m_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = front_reg;
        mem_raddr      = rd_idx_reg;
        stat           = STAT_OK;
        load           = 1'b0;
        move           = 1'b0;
        issue          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    load = 1'b1;
                    unique case (op)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                stat = STAT_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? IDX_W'(DEPTH - 1)
                                                               : front_reg - 1'b1;
                                mem_we     = 1'b1;
                                mem_waddr  = front_next;
                                cnt_next   = cnt_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                stat = STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = wrap_add(front_reg, cnt_reg);
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (!s_tdata[31] && (s_tdata != '0))
                            begin
                                if (s_tdata > 32'(cnt_reg))
                                begin
                                    stat       = STAT_EMPTY;
                                    front_next = wrap_add(front_reg, cnt_reg);
                                    cnt_next   = '0;
                                end
                                else
                                begin
                                    front_next = wrap_add(front_reg, s_tdata[CNT_W-1:0]);
                                    cnt_next   = cnt_reg - s_tdata[CNT_W-1:0];
                                end
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat = STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        OP_LIST:
                        begin
                            if (cnt_reg != '0)
                            begin
                                load           = 1'b0;
                                state_next     = ST_LIST;
                                rd_idx_next    = front_reg;
                                iss_next       = '0;
                                rd_pend_next   = 1'b0;
                                pend_last_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                move  = rd_pend_reg && out_free;
                issue = (iss_reg != cnt_reg) && (!rd_pend_reg || move);
                if (move)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rd_data_reg;
                    m_has_next    = 1'b1;
                    m_status_next = STAT_OK;
                    m_occ_next    = OCC_W'(cnt_reg);
                    m_last_next   = pend_last_reg;
                    rd_pend_next  = 1'b0;
                    if (pend_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if (issue)
                begin
                    mem_re         = 1'b1;
                    rd_idx_next    = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0
                                                                       : rd_idx_reg + 1'b1;
                    iss_next       = iss_reg + 1'b1;
                    pend_last_next = ((iss_reg + 1'b1) == cnt_reg);
                    rd_pend_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_has_next    = 1'b0;
            m_status_next = stat;
            m_occ_next    = OCC_W'(cnt_next);
            m_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            iss_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            pend_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            iss_reg       <= iss_next;
            rd_pend_reg   <= rd_pend_next;
            pend_last_reg <= pend_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_occ_reg    <= m_occ_next;
        m_has_reg    <= m_has_next;
        m_last_reg   <= m_last_next;
    end

    // writes happen only while idle, so a list read never meets a pending write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= s_tdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_occ_reg, m_status_reg, m_data_reg};
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LIST |-> iss_reg <= cnt_reg)
        else $error("list reads beyond entry count");

    a_pend_list: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == ST_LIST)
        else $error("read data pending outside listing");

    a_list_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LIST && $past(state_reg) == ST_LIST |-> $stable(cnt_reg))
        else $error("entry count changed during listing");
`endif

endmodule
